### design/urhb_pkg.sv
// urhb_pkg: shared types, constants and slot arithmetic for the undo/redo history buffer
// used by urhb_ctrl, urhb_datapath, the top level and the checker
// no dependencies
package urhb_pkg;

   // history geometry
   localparam int HISTORY_DEPTH  = 64;
   localparam int SNAPSHOT_WIDTH = 64;
   localparam int SLOT_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int COUNT_W        = $clog2(HISTORY_DEPTH + 1);
   localparam int OFS_W          = COUNT_W + 1;

   // port widths
   localparam int ACTION_W    = 3;
   localparam int VALUE_W     = 64;
   localparam int DEPTH_OUT_W = 6;
   localparam int DEPTH_MAX   = 63;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_RESET   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_RECORD  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REPLACE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_UNDO    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REDO    = 3'd4;

   // controller to datapath commands
   typedef struct packed {
      logic accept;   // take the request transaction and update the history
      logic publish;  // load the response register
   } cmd_type;

   // ring slot of base + ofs, both below the depth
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                  input logic [SLOT_W-1:0] ofs);
      logic [SLOT_W:0] sum;
      sum = {1'b0, base} + {1'b0, ofs};
      if (sum >= (SLOT_W+1)'(HISTORY_DEPTH)) begin
         sum = sum - (SLOT_W+1)'(HISTORY_DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

   // clamp a depth to the output field range
   function automatic logic [DEPTH_OUT_W-1:0] sat_depth(input logic [COUNT_W-1:0] d);
      logic [DEPTH_OUT_W-1:0] r;
      if (int'(d) > DEPTH_MAX) begin
         r = DEPTH_OUT_W'(DEPTH_MAX);
      end else begin
         r = DEPTH_OUT_W'(d);
      end
      return r;
   endfunction

endpackage

### design/urhb_ram.sv
// urhb_ram: generic single write port, single read port ram with registered read
// no dependencies
module urhb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/urhb_ctrl.sv
// urhb_ctrl: transaction sequencing for the history buffer
// depends on urhb_pkg
module urhb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output urhb_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_FILL = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // handshake decode
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign cmd.accept  = req_valid && (state_ff == ST_IDLE);
   assign cmd.publish = (state_ff == ST_FILL) && out_free;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (cmd.publish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid holds until taken
   assign rsp_valid_in = cmd.publish ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/urhb_datapath.sv
// urhb_datapath: ring pointers, cached neighbor entries, snapshot ram and response register
// depends on urhb_pkg and urhb_ram
module urhb_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  urhb_pkg::cmd_type                     cmd,
   input  logic [urhb_pkg::ACTION_W-1:0]         req_action,
   input  logic [urhb_pkg::VALUE_W-1:0]          req_value,
   output logic                                  rsp_done_res,
   output logic                                  rsp_initialized,
   output logic [urhb_pkg::VALUE_W-1:0]          rsp_current_value,
   output logic [urhb_pkg::VALUE_W-1:0]          rsp_undo_target,
   output logic [urhb_pkg::VALUE_W-1:0]          rsp_redo_target,
   output logic [urhb_pkg::DEPTH_OUT_W-1:0]      rsp_undo_depth,
   output logic [urhb_pkg::DEPTH_OUT_W-1:0]      rsp_redo_depth
);

   localparam int SW = urhb_pkg::SNAPSHOT_WIDTH;
   localparam int LW = urhb_pkg::SLOT_W;
   localparam int CW = urhb_pkg::COUNT_W;
   localparam int OW = urhb_pkg::OFS_W;
   localparam int VW = urhb_pkg::VALUE_W;
   localparam int DW = urhb_pkg::DEPTH_OUT_W;

   // ring state
   logic [LW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] cursor_ff, cursor_in;

   // cached entries at cursor, cursor-1 and cursor+1
   logic [SW-1:0] cur_ff, cur_in;
   logic [SW-1:0] prev_ff, prev_in;
   logic [SW-1:0] next_ff, next_in;

   // per transaction status
   logic done_ff, done_in;
   logic fill_prev_ff, fill_prev_in;
   logic fill_next_ff, fill_next_in;

   // ram port
   logic          wr_en, rd_en;
   logic [LW-1:0] wr_addr, rd_addr;
   logic [SW-1:0] rd_data;

   // response register
   logic          out_done_ff, out_init_ff;
   logic [VW-1:0] out_cur_ff, out_undo_ff, out_redo_ff;
   logic [DW-1:0] out_undo_d_ff, out_redo_d_ff;

   logic [SW-1:0] val;
   logic          empty, same;
   logic [OW-1:0] cursor_p1, cursor_p2, count_ext;
   logic [SW-1:0] prev_eff, next_eff;
   logic [CW-1:0] redo_raw;
   logic          init_now;

   assign val       = req_value[SW-1:0];
   assign empty     = (count_ff == '0);
   assign same      = (cur_ff == val);
   assign cursor_p1 = OW'(cursor_ff) + OW'(1);
   assign cursor_p2 = OW'(cursor_ff) + OW'(2);
   assign count_ext = OW'(count_ff);

   // history update on an accepted transaction
   always_comb begin
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      done_in      = done_ff;
      fill_prev_in = fill_prev_ff;
      fill_next_in = fill_next_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      if (cmd.accept) begin
         done_in      = 1'b0;
         fill_prev_in = 1'b0;
         fill_next_in = 1'b0;
         if ((req_action == urhb_pkg::ACT_RESET) ||
             (((req_action == urhb_pkg::ACT_RECORD) ||
               (req_action == urhb_pkg::ACT_REPLACE)) && empty)) begin
            // restart with a single entry
            oldest_in = '0;
            count_in  = CW'(1);
            cursor_in = '0;
            cur_in    = val;
            wr_en     = 1'b1;
            wr_addr   = '0;
         end else begin
            case (req_action)
               urhb_pkg::ACT_RECORD: begin
                  if (!same) begin
                     done_in = 1'b1;
                     prev_in = cur_ff;
                     cur_in  = val;
                     wr_en   = 1'b1;
                     if (cursor_p1 < OW'(urhb_pkg::HISTORY_DEPTH)) begin
                        // append after cursor, dropping redo entries
                        wr_addr   = urhb_pkg::slot_add(oldest_ff, LW'(cursor_p1));
                        count_in  = CW'(cursor_p2);
                        cursor_in = LW'(cursor_p1);
                     end else begin
                        // full: overwrite oldest slot and advance it
                        wr_addr   = oldest_ff;
                        oldest_in = urhb_pkg::slot_add(oldest_ff, LW'(1));
                        count_in  = CW'(urhb_pkg::HISTORY_DEPTH);
                        cursor_in = LW'(urhb_pkg::HISTORY_DEPTH - 1);
                     end
                  end
               end
               urhb_pkg::ACT_REPLACE: begin
                  if (!same) begin
                     done_in  = 1'b1;
                     cur_in   = val;
                     count_in = CW'(cursor_p1);
                     wr_en    = 1'b1;
                     wr_addr  = urhb_pkg::slot_add(oldest_ff, cursor_ff);
                  end
               end
               urhb_pkg::ACT_UNDO: begin
                  if (!empty && (cursor_ff != '0)) begin
                     done_in   = 1'b1;
                     cursor_in = cursor_ff - LW'(1);
                     next_in   = cur_ff;
                     cur_in    = prev_ff;
                     // new undo target comes from the ram
                     if (cursor_ff >= LW'(2)) begin
                        rd_en        = 1'b1;
                        rd_addr      = urhb_pkg::slot_add(oldest_ff, cursor_ff - LW'(2));
                        fill_prev_in = 1'b1;
                     end
                  end
               end
               urhb_pkg::ACT_REDO: begin
                  if (!empty && (cursor_p1 < count_ext)) begin
                     done_in   = 1'b1;
                     cursor_in = LW'(cursor_p1);
                     prev_in   = cur_ff;
                     cur_in    = next_ff;
                     // new redo target comes from the ram
                     if (cursor_p2 < count_ext) begin
                        rd_en        = 1'b1;
                        rd_addr      = urhb_pkg::slot_add(oldest_ff, LW'(cursor_p2));
                        fill_next_in = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end else if (cmd.publish) begin
         prev_in = prev_eff;
         next_in = next_eff;
      end
   end

   // neighbor entries after the ram read
   assign prev_eff = fill_prev_ff ? rd_data : prev_ff;
   assign next_eff = fill_next_ff ? rd_data : next_ff;

   assign init_now = !empty;
   assign redo_raw = init_now ? (count_ff - CW'(cursor_ff) - CW'(1)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      next_ff      <= next_in;
      done_ff      <= done_in;
      fill_prev_ff <= fill_prev_in;
      fill_next_ff <= fill_next_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_done_ff   <= done_ff;
         out_init_ff   <= init_now;
         out_cur_ff    <= init_now ? VW'(cur_ff) : '0;
         out_undo_ff   <= (init_now && (cursor_ff != '0)) ? VW'(prev_eff) : '0;
         out_redo_ff   <= (redo_raw != '0) ? VW'(next_eff) : '0;
         out_undo_d_ff <= urhb_pkg::sat_depth(CW'(cursor_ff));
         out_redo_d_ff <= urhb_pkg::sat_depth(redo_raw);
      end
   end

   assign rsp_done_res      = out_done_ff;
   assign rsp_initialized   = out_init_ff;
   assign rsp_current_value = out_cur_ff;
   assign rsp_undo_target   = out_undo_ff;
   assign rsp_redo_target   = out_redo_ff;
   assign rsp_undo_depth    = out_undo_d_ff;
   assign rsp_redo_depth    = out_redo_d_ff;

   // snapshot store
   urhb_ram #(
      .WIDTH (SW),
      .DEPTH (urhb_pkg::HISTORY_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (val),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

### design/undo_redo_history_buffer_unit.sv
// undo_redo_history_buffer_unit: bounded undo/redo history, one transaction at a time.
// an accepted request moves to the fill state, which registers the response once the
// output is free, after the snapshot ram's registered read of the new neighbor entry;
//   no request is taken until then; a response waiting on rsp_stall delays the next one.
// reset: synchronous, empties the history; ram contents are not cleared, no sweep.
// depends on urhb_pkg, urhb_ctrl, urhb_datapath
module undo_redo_history_buffer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [urhb_pkg::ACTION_W-1:0]        req_action,
   input  logic [urhb_pkg::VALUE_W-1:0]         req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_done_res,
   output logic                                 rsp_initialized,
   output logic [urhb_pkg::VALUE_W-1:0]         rsp_current_value,
   output logic [urhb_pkg::VALUE_W-1:0]         rsp_undo_target,
   output logic [urhb_pkg::VALUE_W-1:0]         rsp_redo_target,
   output logic [urhb_pkg::DEPTH_OUT_W-1:0]     rsp_undo_depth,
   output logic [urhb_pkg::DEPTH_OUT_W-1:0]     rsp_redo_depth
);

   urhb_pkg::cmd_type cmd;

   // sequencing
   urhb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // history and response
   urhb_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_action        (req_action),
      .req_value         (req_value),
      .rsp_done_res      (rsp_done_res),
      .rsp_initialized   (rsp_initialized),
      .rsp_current_value (rsp_current_value),
      .rsp_undo_target   (rsp_undo_target),
      .rsp_redo_target   (rsp_redo_target),
      .rsp_undo_depth    (rsp_undo_depth),
      .rsp_redo_depth    (rsp_redo_depth)
   );

endmodule

### design/urhb_checker.sv
// urhb_checker: port level assertions for undo_redo_history_buffer_unit, bound to the top level
// depends on urhb_pkg
module urhb_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_done_res,
   input logic                                 rsp_initialized,
   input logic [urhb_pkg::VALUE_W-1:0]         rsp_current_value,
   input logic [urhb_pkg::VALUE_W-1:0]         rsp_undo_target,
   input logic [urhb_pkg::VALUE_W-1:0]         rsp_redo_target,
   input logic [urhb_pkg::DEPTH_OUT_W-1:0]     rsp_undo_depth,
   input logic [urhb_pkg::DEPTH_OUT_W-1:0]     rsp_redo_depth
);

   // one transaction in flight: request side stalls right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous transaction in flight");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_current_value) &&
                                    $stable(rsp_undo_depth) && $stable(rsp_redo_depth) &&
                                    $stable(rsp_done_res)))
      else $error("stalled response changed");

   // empty history reports zeros
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_initialized) |-> (rsp_current_value == '0 && rsp_undo_depth == '0 &&
                                           rsp_redo_depth == '0 && !rsp_done_res))
      else $error("empty history reported nonzero status");

   // targets are zero without depth
   a_target_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_undo_depth != '0 || rsp_undo_target == '0) &&
                     (rsp_redo_depth != '0 || rsp_redo_target == '0)))
      else $error("target reported without depth");

   // a fresh response follows an accepted request through the fill state
   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("response without matching request");

endmodule

bind undo_redo_history_buffer_unit urhb_checker u_urhb_checker (.*);

### tb/tb_undo_redo_history_buffer_unit.sv
`timescale 1ns / 100ps
// tb_undo_redo_history_buffer_unit: self-checking testbench for the undo/redo history buffer
// drives edit transactions from a queue, predicts each status and compares field by field
// depends on urhb_pkg and undo_redo_history_buffer_unit
module tb_undo_redo_history_buffer_unit;

   // widths and geometry from the package
   localparam int AW   = urhb_pkg::ACTION_W;
   localparam int VW   = urhb_pkg::VALUE_W;
   localparam int DOW  = urhb_pkg::DEPTH_OUT_W;
   localparam int SW   = urhb_pkg::SNAPSHOT_WIDTH;
   localparam int LW   = urhb_pkg::SLOT_W;
   localparam int CW   = urhb_pkg::COUNT_W;
   localparam int HD   = urhb_pkg::HISTORY_DEPTH;
   localparam int DMAX = urhb_pkg::DEPTH_MAX;

   // run length and timeout
   localparam int RANDOM_EDITS = 1300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 10;

   // action codes the block treats as no-ops
   localparam logic [AW-1:0] ACT_SPARE_A = 3'd5;
   localparam logic [AW-1:0] ACT_SPARE_B = 3'd6;
   localparam logic [AW-1:0] ACT_SPARE_C = 3'd7;

   localparam logic [VW-1:0] SNAP_MASK =
      (SW >= VW) ? {VW{1'b1}} : ((VW'(1) << SW) - 1);

   typedef struct packed {
      logic [AW-1:0] action;
      logic [VW-1:0] value;
   } edit_type;

   typedef struct packed {
      logic           done_res;
      logic           initialized;
      logic [VW-1:0]  current_value;
      logic [VW-1:0]  undo_target;
      logic [VW-1:0]  redo_target;
      logic [DOW-1:0] undo_depth;
      logic [DOW-1:0] redo_depth;
   } hist_status_type;

   // dut ports
   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [AW-1:0]            req_action = urhb_pkg::ACT_RESET;
   logic [VW-1:0]            req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_done_res;
   logic                     rsp_initialized;
   logic [VW-1:0]            rsp_current_value;
   logic [VW-1:0]            rsp_undo_target;
   logic [VW-1:0]            rsp_redo_target;
   logic [DOW-1:0]           rsp_undo_depth;
   logic [DOW-1:0]           rsp_redo_depth;

   // shadow history
   logic [VW-1:0]            shadow_store [HD] = '{default: '0};
   logic [LW-1:0]            oldest_slot = '0;
   logic [CW-1:0]            entry_count = '0;
   logic [LW-1:0]            cursor = '0;

   // bookkeeping
   edit_type                 pending_edits [$];
   hist_status_type          expected_status [$];
   edit_type                 next_edit;
   hist_status_type          oldest_status;
   logic [VW-1:0]            last_value = '0;
   int                       total_edits = 0;
   int                       accepted_edits = 0;
   int                       mismatches = 0;
   int                       cycle_count = 0;
   logic                     calm;

   undo_redo_history_buffer_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_done_res      (rsp_done_res),
      .rsp_initialized   (rsp_initialized),
      .rsp_current_value (rsp_current_value),
      .rsp_undo_target   (rsp_undo_target),
      .rsp_redo_target   (rsp_redo_target),
      .rsp_undo_depth    (rsp_undo_depth),
      .rsp_redo_depth    (rsp_redo_depth)
   );

   // stretch with no idling on either side
   assign calm = (accepted_edits >= 500) && (accepted_edits < 800);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ring slot at an offset from the oldest entry
   function automatic int slot_at(input int ofs);
      return (int'(oldest_slot) + ofs) % HD;
   endfunction

   function automatic void restart_history(input logic [VW-1:0] v);
      oldest_slot     = '0;
      entry_count     = CW'(1);
      cursor          = '0;
      shadow_store[0] = v;
   endfunction

   // apply one edit to the shadow history and return the status it reports
   function automatic hist_status_type apply_edit(input edit_type e);
      hist_status_type s;
      logic [VW-1:0]   v;
      int              nxt;
      int              undo_n;
      int              redo_n;
      s = '0;
      v = e.value & SNAP_MASK;
      case (e.action)
         urhb_pkg::ACT_RESET: begin
            restart_history(v);
         end
         urhb_pkg::ACT_RECORD: begin
            if (entry_count == 0) begin
               restart_history(v);
            end else if (shadow_store[slot_at(int'(cursor))] != v) begin
               nxt = int'(cursor) + 1;
               if (nxt < HD) begin
                  shadow_store[slot_at(nxt)] = v;
                  entry_count = CW'(nxt + 1);
                  cursor      = LW'(nxt);
               end else begin
                  // ring full: the new entry takes the oldest slot
                  shadow_store[oldest_slot] = v;
                  oldest_slot = LW'((int'(oldest_slot) + 1) % HD);
                  entry_count = CW'(HD);
                  cursor      = LW'(HD - 1);
               end
               s.done_res = 1'b1;
            end
         end
         urhb_pkg::ACT_REPLACE: begin
            if (entry_count == 0) begin
               restart_history(v);
            end else if (shadow_store[slot_at(int'(cursor))] != v) begin
               shadow_store[slot_at(int'(cursor))] = v;
               entry_count = CW'(int'(cursor) + 1);
               s.done_res  = 1'b1;
            end
         end
         urhb_pkg::ACT_UNDO: begin
            if (entry_count != 0 && cursor > 0) begin
               cursor     = cursor - LW'(1);
               s.done_res = 1'b1;
            end
         end
         urhb_pkg::ACT_REDO: begin
            if (entry_count != 0 && int'(cursor) + 1 < int'(entry_count)) begin
               cursor     = cursor + LW'(1);
               s.done_res = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // status after the edit
      if (entry_count != 0) begin
         undo_n = int'(cursor);
         redo_n = int'(entry_count) - int'(cursor) - 1;
         s.initialized   = 1'b1;
         s.current_value = shadow_store[slot_at(undo_n)];
         if (undo_n != 0) begin
            s.undo_target = shadow_store[slot_at(undo_n - 1)];
         end
         if (redo_n != 0) begin
            s.redo_target = shadow_store[slot_at(undo_n + 1)];
         end
         s.undo_depth = DOW'((undo_n > DMAX) ? DMAX : undo_n);
         s.redo_depth = DOW'((redo_n > DMAX) ? DMAX : redo_n);
      end
      return s;
   endfunction

   function automatic logic [VW-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // snapshot word for record or replace, often repeating the previous one
   function automatic logic [VW-1:0] pick_value(input int reuse_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < reuse_pct) begin
         return last_value;
      end else if (roll < reuse_pct + 8) begin
         return VW'($urandom_range(0, 3));
      end else if (roll < reuse_pct + 11) begin
         return {VW{1'b1}};
      end
      return rand_word();
   endfunction

   task automatic add_edit(input logic [AW-1:0] action, input logic [VW-1:0] value);
      edit_type e;
      e.action = action;
      e.value  = value;
      pending_edits.insert(pending_edits.size(), e);
      if (action == urhb_pkg::ACT_RECORD || action == urhb_pkg::ACT_REPLACE ||
          action == urhb_pkg::ACT_RESET) begin
         last_value = value;
      end
      total_edits++;
   endtask

   task automatic compare_field(input string name, input logic [VW-1:0] want,
                                input logic [VW-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // driver: presents the next pending transaction, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            next_edit.action = req_action;
            next_edit.value  = req_value;
            expected_status.insert(expected_status.size(), apply_edit(next_edit));
            accepted_edits++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_edits.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
               next_edit = pending_edits.pop_front();
               req_valid  <= 1'b1;
               req_action <= next_edit.action;
               req_value  <= next_edit.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: takes each status transaction and checks it against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $error("status transaction with no edit outstanding");
               mismatches++;
            end else begin
               oldest_status = expected_status.pop_front();
               compare_field("done_res", VW'(oldest_status.done_res),
                             VW'(rsp_done_res));
               compare_field("initialized", VW'(oldest_status.initialized),
                             VW'(rsp_initialized));
               compare_field("current_value", oldest_status.current_value, rsp_current_value);
               compare_field("undo_target", oldest_status.undo_target, rsp_undo_target);
               compare_field("redo_target", oldest_status.redo_target, rsp_redo_target);
               compare_field("undo_depth", VW'(oldest_status.undo_depth),
                             VW'(rsp_undo_depth));
               compare_field("redo_depth", VW'(oldest_status.redo_depth),
                             VW'(rsp_redo_depth));
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 33);
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      int kind;
      int len;
      // moves and spare codes on the empty history, then the first write as record or replace
      add_edit(urhb_pkg::ACT_UNDO, rand_word());
      add_edit(urhb_pkg::ACT_REDO, rand_word());
      add_edit(ACT_SPARE_A, rand_word());
      add_edit(ACT_SPARE_B, '0);
      add_edit(ACT_SPARE_C, {VW{1'b1}});
      add_edit($urandom_range(0, 1) ? urhb_pkg::ACT_RECORD : urhb_pkg::ACT_REPLACE, '0);
      add_edit(urhb_pkg::ACT_RECORD, '0);
      add_edit(urhb_pkg::ACT_RECORD, {VW{1'b1}});
      add_edit(urhb_pkg::ACT_RECORD, {(VW/2){2'b01}});
      add_edit(urhb_pkg::ACT_REPLACE, {(VW/2){2'b10}});
      add_edit(urhb_pkg::ACT_REPLACE, {(VW/2){2'b10}});
      add_edit(urhb_pkg::ACT_UNDO, '0);
      add_edit(urhb_pkg::ACT_UNDO, '0);
      add_edit(urhb_pkg::ACT_UNDO, '0);
      add_edit(urhb_pkg::ACT_REDO, '0);
      // record after undo drops the redo entries
      add_edit(urhb_pkg::ACT_RECORD, 64'h0123_4567_89ab_cdef);
      add_edit(urhb_pkg::ACT_REDO, '0);
      add_edit(urhb_pkg::ACT_UNDO, '0);
      add_edit(urhb_pkg::ACT_REPLACE, 64'hfedc_ba98_7654_3210);
      add_edit(urhb_pkg::ACT_REDO, '0);
      add_edit(ACT_SPARE_A, '0);
      add_edit(urhb_pkg::ACT_RESET, {VW{1'b1}});
      add_edit(urhb_pkg::ACT_RESET, '0);

      // random sequences: long record bursts fill the ring, runs of undo and redo walk it
      while (total_edits < RANDOM_EDITS + 23) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            len = $urandom_range(1, 80);
            repeat (len) add_edit(urhb_pkg::ACT_RECORD, pick_value(12));
         end else if (kind < 55) begin
            len = $urandom_range(1, 70);
            repeat (len) add_edit(urhb_pkg::ACT_UNDO, rand_word());
         end else if (kind < 72) begin
            len = $urandom_range(1, 70);
            repeat (len) add_edit(urhb_pkg::ACT_REDO, rand_word());
         end else if (kind < 84) begin
            len = $urandom_range(1, 3);
            repeat (len) add_edit(urhb_pkg::ACT_REPLACE, pick_value(30));
         end else if (kind < 88) begin
            add_edit(urhb_pkg::ACT_RESET, pick_value(10));
         end else if (kind < 94) begin
            add_edit(ACT_SPARE_A + AW'($urandom_range(0, 2)), rand_word());
         end else begin
            len = $urandom_range(1, 10);
            repeat (len) add_edit(AW'($urandom_range(0, 7)), pick_value(20));
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (accepted_edits < total_edits) @(negedge clock);
      while (expected_status.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
